/* hw/rtl/csem_pkg.sv */
// ----------------------------------------------------------------------------
// csem_pkg: shared definitions for the counting semaphore table
// Sizes, request and status codes, sequencer states and the count store
// word and write-port types.
// ----------------------------------------------------------------------------
package csem_pkg;

  // Table geometry
  localparam int NUM_SLOTS    = 64;
  localparam int COUNT_BITS   = 16;
  localparam int HANDLE_LIMIT = 64;
  localparam int SEARCH_SLOTS = (NUM_SLOTS > HANDLE_LIMIT) ? HANDLE_LIMIT : NUM_SLOTS;
  localparam int IDX_W        = $clog2(NUM_SLOTS);

  // Free-slot search: one group of slots is tested per cycle
  localparam int GRP_SIZE   = 8;
  localparam int OFF_W      = $clog2(GRP_SIZE);
  localparam int NUM_GROUPS = (SEARCH_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  // Field widths on the stream ports
  localparam int REQ_W    = 2;
  localparam int SEM_W    = 6;
  localparam int INIT_W   = 16;
  localparam int STATUS_W = 3;
  localparam int HANDLE_W = 6;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 16;

  typedef logic [IDX_W-1:0]      slot_idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    count_t max_cnt;
    count_t cur_cnt;
  } count_pair_t;

  // Write port of the count store
  typedef struct packed {
    logic        en;
    slot_idx_t   addr;
    count_pair_t data;
  } store_wr_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT    = 2'd0,
    REQ_DESTROY = 2'd1,
    REQ_POST    = 2'd2,
    REQ_WAIT    = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_NO_FREE     = 3'd1,
    STAT_UNUSED      = 3'd2,
    STAT_AT_MAX      = 3'd3,
    STAT_WOULD_BLOCK = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_UPDATE,
    S_DONE
  } seq_state_e;

endpackage

/* hw/rtl/csem_store.sv */
// ----------------------------------------------------------------------------
// csem_store: count memory of the semaphore table
// One write port and one read port with registered read data; each word
// holds the maximum and the current count of one slot.
// ----------------------------------------------------------------------------
module csem_store
  import csem_pkg::*;
(
  input  logic        clk_i,
  input  store_wr_t   wr_i,
  input  slot_idx_t   rd_addr_i,
  output count_pair_t rd_data_o
);

  count_pair_t mem_q [NUM_SLOTS];
  count_pair_t rd_data_q;

  // Write one word when enabled
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

/* hw/rtl/counting_semaphore_table.sv */
// ----------------------------------------------------------------------------
// counting_semaphore_table: bank of counting semaphores
// Init, destroy, post and wait requests on a table of counting semaphores,
// one status and handle transfer per request.
// ----------------------------------------------------------------------------
// Each request yields exactly one result. Destroy, and any destroy, post or
// wait on an unused slot, passes from accept straight to the result; post
// and wait on a slot in use take a read of the count memory and then a
// read-modify-write through one shared compare and step unit; init first
// searches for the lowest free slot, eight slots per cycle. The input is
// ready only while no request is in progress; the output register lets the
// next request be accepted while a result waits.
// The used bits are cleared by reset directly, so no clearing pass is needed.
module counting_semaphore_table
  import csem_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [5:0] sem_index, [21:6] init_count, [23:22] zero
  input  logic [S_DATA_W-1:0] s_axis_tdata,
  // [1:0] req_type
  input  logic [REQ_W-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] status, [8:3] handle, [15:9] zero
  output logic [M_DATA_W-1:0] m_axis_tdata
);

  seq_state_e state_q, state_d;

  logic [NUM_SLOTS-1:0] slot_used_q;
  req_e                 kind_q, kind_d;
  slot_idx_t            idx_q, idx_d;
  count_t               cnt_q, cnt_d;
  status_e              status_q, status_d;
  logic [HANDLE_W-1:0]  handle_q, handle_d;
  logic [GRP_W-1:0]     grp_q, grp_d;

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [HANDLE_W-1:0]  out_handle_q;

  store_wr_t            store_wr;
  count_pair_t          rd_data;

  // Unpack the input transfer
  req_e          in_kind;
  logic [SEM_W-1:0] in_sem;
  count_t        in_cnt;
  slot_idx_t     in_idx;
  logic          in_fire;
  logic          in_hit;

  assign in_kind = req_e'(s_axis_tuser);
  assign in_sem  = s_axis_tdata[SEM_W-1:0];
  assign in_cnt  = COUNT_BITS'(s_axis_tdata[SEM_W +: INIT_W]);
  assign in_idx  = IDX_W'(in_sem);
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign in_hit  = (32'(in_sem) < 32'(NUM_SLOTS)) && slot_used_q[in_idx];

  // Test one group of slots for the lowest free one
  logic [GRP_SIZE-1:0] grp_free;
  logic                found;
  logic [OFF_W-1:0]    found_off;
  slot_idx_t           found_slot;
  logic                last_grp;

  always_comb begin
    int pos;
    pos       = 0;
    grp_free  = '0;
    found     = 1'b0;
    found_off = '0;
    for (int j = 0; j < GRP_SIZE; j++) begin
      pos = int'(grp_q) * GRP_SIZE + j;
      if (pos < SEARCH_SLOTS) begin
        grp_free[j] = ~slot_used_q[IDX_W'(pos)];
      end
    end
    for (int j = GRP_SIZE - 1; j >= 0; j--) begin
      if (grp_free[j]) begin
        found     = 1'b1;
        found_off = OFF_W'(j);
      end
    end
  end

  assign found_slot = IDX_W'(int'(grp_q) * GRP_SIZE + int'(found_off));
  assign last_grp   = (grp_q == GRP_W'(NUM_GROUPS - 1));

  // Shared compare and step unit for post and wait
  logic   is_post;
  count_t cmp_a, cmp_b, step_sum;
  logic   cmp_lt;

  assign is_post  = (kind_q == REQ_POST);
  assign cmp_a    = is_post ? rd_data.cur_cnt : '0;
  assign cmp_b    = is_post ? rd_data.max_cnt : rd_data.cur_cnt;
  assign cmp_lt   = (cmp_a < cmp_b);
  assign step_sum = rd_data.cur_cnt + (is_post ? count_t'(1) : '1);

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_kind == REQ_INIT) begin
            state_d = S_SEARCH;
          end else if (in_hit && (in_kind != REQ_DESTROY)) begin
            state_d = S_READ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SEARCH: begin
        if (found || last_grp) begin
          state_d = S_DONE;
        end
      end
      S_READ:   state_d = S_UPDATE;
      S_UPDATE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath updates of the sequencer
  logic used_set, used_clr, load_out;

  always_comb begin
    s_axis_tready = 1'b0;
    store_wr      = '0;
    used_set      = 1'b0;
    used_clr      = 1'b0;
    load_out      = 1'b0;
    kind_d        = kind_q;
    idx_d         = idx_q;
    cnt_d         = cnt_q;
    status_d      = status_q;
    handle_d      = handle_q;
    grp_d         = grp_q;
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire) begin
          kind_d   = in_kind;
          idx_d    = in_idx;
          cnt_d    = in_cnt;
          handle_d = '0;
          grp_d    = '0;
          status_d = STAT_OK;
          if (in_kind != REQ_INIT) begin
            if (!in_hit) begin
              status_d = STAT_UNUSED;
            end else if (in_kind == REQ_DESTROY) begin
              used_clr = 1'b1;
            end
          end
        end
      end
      S_SEARCH: begin
        if (found) begin
          used_set               = 1'b1;
          idx_d                  = found_slot;
          handle_d               = HANDLE_W'(found_slot);
          store_wr.en            = 1'b1;
          store_wr.addr          = found_slot;
          store_wr.data.max_cnt  = cnt_q;
          store_wr.data.cur_cnt  = cnt_q;
        end else if (last_grp) begin
          status_d = STAT_NO_FREE;
        end else begin
          grp_d = grp_q + GRP_W'(1);
        end
      end
      S_READ: begin
        // hold the address while the count word is read
      end
      S_UPDATE: begin
        if (cmp_lt) begin
          store_wr.en           = 1'b1;
          store_wr.addr         = idx_q;
          store_wr.data.max_cnt = rd_data.max_cnt;
          store_wr.data.cur_cnt = step_sum;
        end else begin
          status_d = is_post ? STAT_AT_MAX : STAT_WOULD_BLOCK;
        end
      end
      S_DONE: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  csem_store u_store (
    .clk_i     (clk_i),
    .wr_i      (store_wr),
    .rd_addr_i (idx_q),
    .rd_data_o (rd_data)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_used_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (used_set) begin
        slot_used_q[idx_d] <= 1'b1;
      end
      if (used_clr) begin
        slot_used_q[in_idx] <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    idx_q    <= idx_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
    handle_q <= handle_d;
    grp_q    <= grp_d;
    if (load_out) begin
      out_status_q <= status_q;
      out_handle_q <= handle_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(M_DATA_W - STATUS_W - HANDLE_W)'(0), out_handle_q, out_status_q};

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the counting semaphore table
// Drives init, destroy, post and wait requests over the stream input, tracks
// the expected slot table in a scoreboard and compares every status and
// handle transfer in order. A short directed sequence covers the corner
// cases, then fill and empty bursts of random requests run under four idle
// and stall phases.
// ----------------------------------------------------------------------------
module tb_top;
  import csem_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int ITEMS_PER_PHASE = 375;
  localparam int NUM_PHASES      = 4;
  localparam int REPORT_LIMIT    = 10;

  typedef struct {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
  } sem_result_t;

  // Expected slot table and the queue of outstanding results
  class sem_bank_scoreboard;
    bit          used [NUM_SLOTS];
    count_t      max_cnt [NUM_SLOTS];
    count_t      cur_cnt [NUM_SLOTS];
    sem_result_t pending_results [$];
    int          errors;
    int          num_used;

    function new();
      errors   = 0;
      num_used = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        used[i]    = 1'b0;
        max_cnt[i] = '0;
        cur_cnt[i] = '0;
      end
    endfunction

    // Apply one accepted request to the table and queue its result
    function void note_request(req_e kind, logic [SEM_W-1:0] idx,
                               logic [INIT_W-1:0] cnt);
      sem_result_t res;
      count_t      cut_cnt;
      bit          found;
      res.status = STAT_OK;
      res.handle = '0;
      cut_cnt    = count_t'(cnt);
      found      = 1'b0;
      if (kind == REQ_INIT) begin
        for (int i = 0; i < SEARCH_SLOTS && !found; i++) begin
          if (!used[i]) begin
            used[i]    = 1'b1;
            max_cnt[i] = cut_cnt;
            cur_cnt[i] = cut_cnt;
            res.handle = HANDLE_W'(i);
            found      = 1'b1;
            num_used++;
          end
        end
        if (!found) res.status = STAT_NO_FREE;
      end else if (int'(idx) >= NUM_SLOTS || !used[idx]) begin
        res.status = STAT_UNUSED;
      end else begin
        case (kind)
          REQ_DESTROY: begin
            used[idx]    = 1'b0;
            max_cnt[idx] = '0;
            cur_cnt[idx] = '0;
            num_used--;
          end
          REQ_POST: begin
            if (cur_cnt[idx] < max_cnt[idx]) cur_cnt[idx] = cur_cnt[idx] + 1'b1;
            else res.status = STAT_AT_MAX;
          end
          default: begin
            if (cur_cnt[idx] != '0) cur_cnt[idx] = cur_cnt[idx] - 1'b1;
            else res.status = STAT_WOULD_BLOCK;
          end
        endcase
      end
      pending_results.push_back(res);
    endfunction

    // Compare one result transfer against the oldest expectation
    function void check_result(logic [M_DATA_W-1:0] data);
      sem_result_t         exp_res;
      logic [STATUS_W-1:0] got_status;
      logic [HANDLE_W-1:0] got_handle;
      got_status = data[STATUS_W-1:0];
      got_handle = data[STATUS_W +: HANDLE_W];
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: unexpected result status %0d handle %0d", got_status,
                   got_handle);
        return;
      end
      exp_res = pending_results.pop_front();
      if (got_status !== exp_res.status || got_handle !== exp_res.handle) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("ERROR: status exp %0d got %0d, handle exp %0d got %0d",
                   exp_res.status, got_status, exp_res.handle, got_handle);
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [REQ_W-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;

  sem_bank_scoreboard sem_sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;
  int send_pcts [NUM_PHASES] = '{0, 53, 0, 23};
  int recv_pcts [NUM_PHASES] = '{0, 0, 53, 23};

  counting_semaphore_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Stall the result side at random
  always @(posedge clk_i) begin
    m_axis_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
  end

  // Check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sem_sb.check_result(m_axis_tdata);
  end

  // Abort when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one request, with a random gap ahead of it; returns at the transfer
  task automatic send_request(req_e kind, logic [SEM_W-1:0] idx,
                              logic [INIT_W-1:0] cnt);
    int gap;
    gap = 0;
    while (int'($urandom_range(99)) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, cnt, idx};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sem_sb.note_request(kind, idx, cnt);
  endtask

  // Hold the request side until every outstanding result has come back
  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sem_sb.pending_results.size() != 0);
  endtask

  // Mostly address slots in use, sometimes any slot
  function automatic logic [SEM_W-1:0] pick_slot();
    int used_list [$];
    for (int i = 0; i < NUM_SLOTS; i++)
      if (sem_sb.used[i]) used_list.push_back(i);
    if (used_list.size() == 0 || $urandom_range(99) < 15) return SEM_W'($urandom);
    return SEM_W'(used_list[$urandom_range(used_list.size() - 1)]);
  endfunction

  // Small counts reach both limits quickly; extremes and wide values too
  function automatic logic [INIT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 40) return INIT_W'($urandom_range(3));
    if (r < 55) return '1;
    if (r < 60) return 16'hFFFE;
    if (r < 65) return '0;
    return INIT_W'($urandom);
  endfunction

  initial begin
    req_e kind;
    int   pick;
    int   no_free_tries;
    bit   filling;
    sem_sb        = new();
    filling       = 1'b1;
    no_free_tries = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unused slots, zero and full-scale counts, both limits, reuse
    send_request(REQ_WAIT,    6'd5,  16'h0000);
    send_request(REQ_POST,    6'd63, 16'hFFFF);
    send_request(REQ_DESTROY, 6'd0,  16'h1234);
    send_request(REQ_INIT,    6'd63, 16'h0000);
    send_request(REQ_POST,    6'd0,  16'h0000);
    send_request(REQ_WAIT,    6'd0,  16'h0000);
    send_request(REQ_INIT,    6'd0,  16'hFFFF);
    send_request(REQ_POST,    6'd1,  16'h0000);
    send_request(REQ_WAIT,    6'd1,  16'h0000);
    send_request(REQ_POST,    6'd1,  16'hFFFF);
    send_request(REQ_INIT,    6'd42, 16'h0001);
    send_request(REQ_WAIT,    6'd2,  16'h0000);
    send_request(REQ_WAIT,    6'd2,  16'h0000);
    send_request(REQ_POST,    6'd2,  16'h0000);
    send_request(REQ_POST,    6'd2,  16'h0000);
    send_request(REQ_DESTROY, 6'd0,  16'h0000);
    send_request(REQ_DESTROY, 6'd0,  16'h0000);
    send_request(REQ_INIT,    6'd21, 16'hA5A5);
    send_request(REQ_INIT,    6'd0,  16'h5A5A);
    send_request(REQ_DESTROY, 6'd63, 16'hFFFF);
    send_request(REQ_WAIT,    6'd3,  16'h0000);
    hold_until_drained();

    // Random: alternate fill bursts up to a full table and empty bursts
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (filling && no_free_tries >= 6) filling = 1'b0;
        if (!filling && sem_sb.num_used <= 3) begin
          filling       = 1'b1;
          no_free_tries = 0;
        end
        pick = $urandom_range(99);
        if (filling) begin
          if (pick < 45)      kind = REQ_INIT;
          else if (pick < 50) kind = REQ_DESTROY;
          else if (pick < 75) kind = REQ_POST;
          else                kind = REQ_WAIT;
        end else begin
          if (pick < 5)       kind = REQ_INIT;
          else if (pick < 45) kind = REQ_DESTROY;
          else if (pick < 72) kind = REQ_POST;
          else                kind = REQ_WAIT;
        end
        if (kind == REQ_INIT && sem_sb.num_used >= SEARCH_SLOTS) no_free_tries++;
        send_request(kind, pick_slot(), pick_count());
      end
      hold_until_drained();
    end

    // Let the last results settle, then report
    s_axis_tvalid <= 1'b0;
    while (sem_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sem_sb.errors == 0 && sem_sb.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* counting_semaphore_table.f */
hw/rtl/csem_pkg.sv
hw/rtl/csem_store.sv
hw/rtl/counting_semaphore_table.sv
tb/tb_top.sv
